@@ hw/rtl/kal_pkg.sv @@
// kal_pkg: shared types, widths and codes of the three-axis kalman smoother
// no dependencies; imported by every module of the block

package kal_pkg;

	// fixed field widths
	localparam int EST_W    = 16;
	localparam int COV_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int FIELD_W  = 16;
	localparam int CLAMP_W  = 7;
	localparam int NOISE_W  = 16;
	localparam int CNT_W    = $clog2(GAIN_W);

	// default parameter values
	localparam int FRAC_BITS_DEF    = 8;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// apb port
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	// register indexes
	typedef enum logic [1:0] {
		REG_PROC_NOISE  = 2'd0,
		REG_MEAS_NOISE  = 2'd1,
		REG_CLAMP_THR   = 2'd2,
		REG_CLAMP_VAL   = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} kal_state_t;

	// sequencer strobes to the axis datapaths
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} kal_ctl_t;

	// configuration values seen by the axis datapaths
	typedef struct packed {
		logic [NOISE_W-1:0] proc_noise;
		logic [NOISE_W-1:0] meas_noise;
		logic [CLAMP_W-1:0] clamp_thr;
		logic [CLAMP_W-1:0] clamp_val;
	} kal_cfg_t;

endpackage

@@ hw/rtl/kal_regs.sv @@
// kal_regs: apb configuration registers of the kalman smoother
// depends on kal_pkg

module kal_regs import kal_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output kal_cfg_t          cfg
);

	// noise reset values follow the fraction width; clamp reset values are fixed
	localparam logic [NOISE_W-1:0] PN_RST = NOISE_W'(1 << (FRAC_BITS - 1));
	localparam logic [NOISE_W-1:0] MN_RST = NOISE_W'((9 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CLAMP_W-1:0] THR_RST = CLAMP_W'(89);
	localparam logic [CLAMP_W-1:0] CLV_RST = CLAMP_W'(90);

	kal_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.proc_noise <= PN_RST;
			cfg_q.meas_noise <= MN_RST;
			cfg_q.clamp_thr  <= THR_RST;
			cfg_q.clamp_val  <= CLV_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROC_NOISE: cfg_q.proc_noise <= pwdata[NOISE_W-1:0];
				REG_MEAS_NOISE: cfg_q.meas_noise <= pwdata[NOISE_W-1:0];
				REG_CLAMP_THR:  cfg_q.clamp_thr  <= pwdata[CLAMP_W-1:0];
				REG_CLAMP_VAL:  cfg_q.clamp_val  <= pwdata[CLAMP_W-1:0];
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (idx)
			REG_PROC_NOISE: prdata = APB_DW'(cfg_q.proc_noise);
			REG_MEAS_NOISE: prdata = APB_DW'(cfg_q.meas_noise);
			REG_CLAMP_THR:  prdata = APB_DW'(cfg_q.clamp_thr);
			REG_CLAMP_VAL:  prdata = APB_DW'(cfg_q.clamp_val);
		endcase
	end

endmodule

@@ hw/rtl/kal_axis.sv @@
// kal_axis: one axis of the smoother, bit-serial gain divider feeding
// bit-serial multipliers for the estimate and covariance updates
// depends on kal_pkg

module kal_axis import kal_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kal_ctl_t                  ctl,
	input  kal_cfg_t                  cfg,
	input  logic [FIELD_W-1:0]        sample,
	output logic signed [EST_W-1:0]   est_new
);

	// datapath widths
	localparam int SFX_W  = SAMPLE_WIDTH + FRAC_BITS;
	localparam int DIFF_W = ((SFX_W > EST_W) ? SFX_W : EST_W) + 1;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int CALC_W = DIFF_W + 1;
	localparam int DEN_W  = COV_W + 1;
	localparam int ACC2_W = COV_W + GAIN_W;

	localparam logic [COV_W-1:0] COV_RST = COV_W'(1 << FRAC_BITS);
	localparam logic [COV_W-1:0] COV_MAX = '1;
	localparam logic signed [CALC_W-1:0] EST_HI = CALC_W'((1 << (EST_W - 1)) - 1);
	localparam logic signed [CALC_W-1:0] EST_LO = CALC_W'(-(1 << (EST_W - 1)));

	// filter state
	logic signed [EST_W-1:0]  est_q;
	logic [COV_W-1:0]         cov_q;

	// per-item working registers
	logic [COV_W-1:0]         pred_q;
	logic [DEN_W-1:0]         denom_q;
	logic [DEN_W-1:0]         rem_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [ACC2_W-1:0]        acc2_q;

	// load-time values
	logic [DEN_W-1:0]         pred_sum;
	logic [COV_W-1:0]         pred;
	logic signed [DIFF_W-1:0] sfx_ext;
	logic signed [DIFF_W-1:0] est_ext;

	// one divider step
	logic [DEN_W:0]           rem_dbl;
	logic [DEN_W:0]           rem_sub;
	logic                     q_fits;
	logic                     q_bit;
	logic signed [PROD_W-1:0] add_est;
	logic [ACC2_W-1:0]        add_cov;

	// update values
	logic signed [CALC_W-1:0] e_sum;
	logic signed [CALC_W-1:0] thr;
	logic signed [CALC_W-1:0] clv;
	logic signed [CALC_W-1:0] e_clamp;
	logic [ACC2_W-1:0]        cov_full;

	// predicted covariance with saturation, sample lifted to fixed point
	always_comb begin
		pred_sum = {1'b0, cov_q} + {1'b0, cfg.proc_noise};
		pred     = pred_sum[COV_W] ? COV_MAX : pred_sum[COV_W-1:0];
		sfx_ext  = DIFF_W'($signed(sample[SAMPLE_WIDTH-1:0])) <<< FRAC_BITS;
		est_ext  = DIFF_W'(est_q);
	end

	// restoring divider step, one gain bit msb first
	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_sub = rem_dbl - {1'b0, denom_q};
		q_fits  = (rem_dbl >= {1'b0, denom_q});
		// zero measurement noise: gain is all ones, or zero for zero covariance
		if (cfg.meas_noise == '0) begin
			q_bit = (pred_q != '0);
		end else begin
			q_bit = q_fits;
		end
		add_est = q_bit ? PROD_W'(diff_q) : PROD_W'(0);
		add_cov = q_bit ? ACC2_W'(pred_q) : ACC2_W'(0);
	end

	// estimate update, clamp and saturation; covariance update
	always_comb begin
		e_sum   = CALC_W'(est_q) + CALC_W'($signed(acc_q[PROD_W-1:GAIN_W]));
		thr     = CALC_W'({cfg.clamp_thr, FRAC_BITS'(0)});
		clv     = CALC_W'({cfg.clamp_val, FRAC_BITS'(0)});
		priority if (e_sum > thr) begin
			e_clamp = clv;
		end else if (e_sum < -thr) begin
			e_clamp = -clv;
		end else begin
			e_clamp = e_sum;
		end
		priority if (e_clamp > EST_HI) begin
			est_new = EST_HI[EST_W-1:0];
		end else if (e_clamp < EST_LO) begin
			est_new = EST_LO[EST_W-1:0];
		end else begin
			est_new = e_clamp[EST_W-1:0];
		end
		cov_full = {pred_q, GAIN_W'(0)} - acc2_q;
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= COV_RST;
		end else if (ctl.finish) begin
			est_q <= est_new;
			cov_q <= cov_full[ACC2_W-1:GAIN_W];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pred_q  <= pred;
			denom_q <= {1'b0, pred} + {1'b0, cfg.meas_noise};
			rem_q   <= {1'b0, pred};
			diff_q  <= sfx_ext - est_ext;
			acc_q   <= '0;
			acc2_q  <= '0;
		end else if (ctl.step) begin
			rem_q   <= q_fits ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
			acc_q   <= (acc_q <<< 1) + add_est;
			acc2_q  <= (acc2_q << 1) + add_cov;
		end
	end

endmodule

@@ hw/rtl/kal_ctrl.sv @@
// kal_ctrl: sequencer for load, serial gain steps and the final update
// depends on kal_pkg

module kal_ctrl import kal_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  logic     out_free,
	output logic     busy,
	output kal_ctl_t ctl
);

	kal_state_t       state_q;
	kal_state_t       state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             last_step;

	assign last_step = (cnt_q == CNT_W'(GAIN_W - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nxt = ST_DIV;
			ST_DIV:  if (last_step) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = accept;
			end
			ST_DIV:  ctl.step = 1'b1;
			ST_DONE: ctl.finish = out_free;
			default: busy = 1'b1;
		endcase
	end

	// state and gain bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/three_axis_scalar_kalman.sv @@
// three_axis_scalar_kalman: top level, three axis filters, sequencer,
// apb registers and the result word register
// depends on kal_pkg, kal_regs, kal_axis, kal_ctrl
//
// channel   | direction | handshake                   | word
// ----------+-----------+-----------------------------+---------------------------------
// sample    | in        | sample_valid / sample_stall | sample_x, sample_y, sample_z
// result    | out       | result_valid / result_stall | filtered_x, filtered_y, filtered_z
// config    | in        | apb psel/penable/pwrite     | paddr, pwdata, prdata
//
// a word is loaded on accept, takes one divider step per gain bit, then the update once the result register is free
// the 16-step bit-serial gain divider is shared by both multiplies
// the three axes run side by side in their own datapaths
// a finished word waits in the result register; the next sample is taken meanwhile
// reset restores estimates to zero, covariances to one and registers to defaults

module three_axis_scalar_kalman import kal_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic signed [FIELD_W-1:0] sample_x,
	input  logic signed [FIELD_W-1:0] sample_y,
	input  logic signed [FIELD_W-1:0] sample_z,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [EST_W-1:0]  filtered_x,
	output logic signed [EST_W-1:0]  filtered_y,
	output logic signed [EST_W-1:0]  filtered_z,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready
);

	kal_cfg_t                cfg;
	kal_ctl_t                ctl;
	logic                    busy;
	logic                    accept;
	logic                    out_free;
	logic signed [EST_W-1:0] est_x;
	logic signed [EST_W-1:0] est_y;
	logic signed [EST_W-1:0] est_z;
	logic                    result_valid_q;
	logic signed [EST_W-1:0] filtered_x_q;
	logic signed [EST_W-1:0] filtered_y_q;
	logic signed [EST_W-1:0] filtered_z_q;

	// handshake
	assign sample_stall = busy;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;

	kal_regs #(
		.FRAC_BITS (FRAC_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (ctl)
	);

	kal_axis #(
		.FRAC_BITS    (FRAC_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg),
		.sample  (sample_x),
		.est_new (est_x)
	);

	kal_axis #(
		.FRAC_BITS    (FRAC_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg),
		.sample  (sample_y),
		.est_new (est_y)
	);

	kal_axis #(
		.FRAC_BITS    (FRAC_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_axis_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg),
		.sample  (sample_z),
		.est_new (est_z)
	);

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			filtered_x_q <= est_x;
			filtered_y_q <= est_y;
			filtered_z_q <= est_z;
		end
	end

	assign result_valid = result_valid_q;
	assign filtered_x   = filtered_x_q;
	assign filtered_y   = filtered_y_q;
	assign filtered_z   = filtered_z_q;

`ifndef SYNTH
	// an accepted sample raises the sample stall, blocking the next one
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sample_stall)
		else $error("sample taken while previous word in flight");

	// a finished word shows up as a valid result
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> result_valid)
		else $error("finished word not presented");

	// a new result only follows an update
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl.finish))
		else $error("result valid without an update");

	// never overwrite a stalled result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(result_valid && result_stall))
		else $error("stalled result overwritten");

	// strobes to the datapaths exclude each other
	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.step, ctl.finish}))
		else $error("conflicting datapath strobes");
`endif

endmodule

@@ dv/three_axis_scalar_kalman_tb.sv @@
`timescale 1ns / 1ps
// three_axis_scalar_kalman_tb: self-checking bench for the three-axis kalman smoother
// holds a fixed-point filter predictor, a queued sample driver, a result monitor and apb writes
// depends on kal_pkg and three_axis_scalar_kalman

module three_axis_scalar_kalman_tb import kal_pkg::*; ();

	localparam int     FRAC         = FRAC_BITS_DEF;
	localparam longint COV_SAT      = 65535;
	localparam longint GAIN_SAT     = 65535;
	localparam longint GAIN_ONE     = 65536;
	localparam longint EST_HI       = 32767;
	localparam longint EST_LO       = -32768;
	localparam int     LAT_CYCLES   = 24;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     CYCLE_LIMIT  = 300000;
	localparam int     MAX_REPORTS  = 10;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} accel_word_t;

	typedef struct packed {
		logic signed [EST_W-1:0] x;
		logic signed [EST_W-1:0] y;
		logic signed [EST_W-1:0] z;
	} filt_word_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [FIELD_W-1:0]  sample_x     = '0;
	logic signed [FIELD_W-1:0]  sample_y     = '0;
	logic signed [FIELD_W-1:0]  sample_z     = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [EST_W-1:0]    filtered_x;
	logic signed [EST_W-1:0]    filtered_y;
	logic signed [EST_W-1:0]    filtered_z;
	logic                       psel         = 1'b0;
	logic                       penable      = 1'b0;
	logic                       pwrite       = 1'b0;
	logic [APB_AW-1:0]          paddr        = '0;
	logic [APB_DW-1:0]          pwdata       = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;

	// predictor state and register copy
	kal_cfg_t                   filt_cfg;
	logic signed [EST_W-1:0]    est_q [3];
	logic [COV_W-1:0]           cov_q [3];

	accel_word_t                pending_samples [$];
	filt_word_t                 expected_filt [$];
	accel_word_t                cur_word;
	filt_word_t                 exp_word;
	filt_word_t                 got_word;

	int                         src_idle_pct  = 0;
	int                         sink_idle_pct = 0;
	int                         hold_req      = 0;
	int                         hold_seen     = 0;
	int                         hold_left     = 0;
	int                         drift_center  = 0;
	int                         err_count     = 0;
	int                         results_seen  = 0;
	int                         cycle_count   = 0;

	three_axis_scalar_kalman dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.sample_z     (sample_z),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.filtered_x   (filtered_x),
		.filtered_y   (filtered_y),
		.filtered_z   (filtered_z),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one kalman step on one axis, returns the clamped estimate
	function automatic logic signed [EST_W-1:0] axis_update(int a, logic signed [FIELD_W-1:0] s);
		longint pred, denom, gain, e, thr, clv;
		pred = longint'(cov_q[a]) + longint'(filt_cfg.proc_noise);
		if (pred > COV_SAT)
			pred = COV_SAT;
		denom = pred + longint'(filt_cfg.meas_noise);
		if (denom == 0) begin
			gain = 0;
		end else begin
			gain = (pred <<< 16) / denom;
			if (gain > GAIN_SAT)
				gain = GAIN_SAT;
		end
		e = longint'(est_q[a]);
		// correction floors toward minus infinity
		e = e + ((((longint'(s) <<< FRAC) - e) * gain) >>> 16);
		cov_q[a] = COV_W'(((GAIN_ONE - gain) * pred) >>> 16);
		thr = longint'(filt_cfg.clamp_thr) <<< FRAC;
		clv = longint'(filt_cfg.clamp_val) <<< FRAC;
		// positive limit wins over negative
		if (e > thr)
			e = clv;
		else if (e < -thr)
			e = -clv;
		if (e > EST_HI)
			e = EST_HI;
		if (e < EST_LO)
			e = EST_LO;
		est_q[a] = EST_W'(e);
		return est_q[a];
	endfunction

	function automatic filt_word_t kal_step(accel_word_t w);
		filt_word_t r;
		r.x = axis_update(0, w.x);
		r.y = axis_update(1, w.y);
		r.z = axis_update(2, w.z);
		return r;
	endfunction

	// one random axis sample: slow drift, small values, full range or extremes
	function automatic logic signed [FIELD_W-1:0] random_axis();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			v = $urandom_range(24);
			return FIELD_W'(drift_center + v - 12);
		end
		if (pick < 70) begin
			v = $urandom_range(400);
			return FIELD_W'(v - 200);
		end
		if (pick < 90)
			return FIELD_W'($urandom());
		case ($urandom_range(3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return -16'sd1;
		endcase
	endfunction

	function automatic accel_word_t random_word();
		accel_word_t w;
		w.x = random_axis();
		w.y = random_axis();
		w.z = random_axis();
		return w;
	endfunction

	// apb write: setup phase then access phase, held until pready
	task automatic cfg_write(reg_idx_t idx, logic [NOISE_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PROC_NOISE: filt_cfg.proc_noise = val;
			REG_MEAS_NOISE: filt_cfg.meas_noise = val;
			REG_CLAMP_THR:  filt_cfg.clamp_thr  = val[CLAMP_W-1:0];
			REG_CLAMP_VAL:  filt_cfg.clamp_val  = val[CLAMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_filter(logic [15:0] pn, logic [15:0] mn,
			logic [15:0] thr, logic [15:0] cv);
		cfg_write(REG_PROC_NOISE, pn);
		cfg_write(REG_MEAS_NOISE, mn);
		cfg_write(REG_CLAMP_THR, thr);
		cfg_write(REG_CLAMP_VAL, cv);
	endtask

	task automatic random_filter();
		logic [15:0] pn;
		logic [15:0] mn;
		case ($urandom_range(3))
			0: pn = 16'($urandom_range(255));
			1: pn = 16'($urandom_range(65535));
			2: pn = 16'd0;
			default: pn = 16'hffff;
		endcase
		case ($urandom_range(4))
			0: mn = 16'($urandom_range(1023));
			1: mn = 16'($urandom_range(65535));
			2: mn = 16'd0;
			3: mn = 16'd1;
			default: mn = 16'hffff;
		endcase
		set_filter(pn, mn, 16'($urandom_range(127)), 16'($urandom_range(127)));
	endtask

	// sender holds back until every sample is through and every word is checked
	task automatic wait_drained();
		// look between edges so the driver's queue pops and valid updates have settled
		while (pending_samples.size() != 0 || sample_valid || expected_filt.size() != 0)
			@(negedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	// sample driver: predict on accept, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall)
				expected_filt.push_back(kal_step(cur_word));
			if (!sample_valid || !sample_stall) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_word = pending_samples.pop_front();
					sample_valid <= 1'b1;
					sample_x     <= cur_word.x;
					sample_y     <= cur_word.y;
					sample_z     <= cur_word.z;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result stall: random back-pressure plus requested long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left    = hold_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < sink_idle_pct);
			end
		end
	end

	// result monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			got_word.x = filtered_x;
			got_word.y = filtered_y;
			got_word.z = filtered_z;
			if (expected_filt.size() == 0) begin
				err_count = err_count + 1;
				if (err_count <= MAX_REPORTS)
					$display("unexpected result word %0d: x=%0d y=%0d z=%0d",
						results_seen, got_word.x, got_word.y, got_word.z);
			end else begin
				exp_word = expected_filt.pop_front();
				if (got_word.x !== exp_word.x || got_word.y !== exp_word.y ||
						got_word.z !== exp_word.z) begin
					err_count = err_count + 1;
					if (err_count <= MAX_REPORTS)
						$display("result %0d: exp x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
							results_seen, exp_word.x, exp_word.y, exp_word.z,
							got_word.x, got_word.y, got_word.z);
				end
			end
			results_seen = results_seen + 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("three_axis_scalar_kalman_tb failed");
			$finish;
		end
	end

	initial begin
		// reset values of the filter
		filt_cfg.proc_noise = 16'd128;
		filt_cfg.meas_noise = 16'd230;
		filt_cfg.clamp_thr  = 7'd89;
		filt_cfg.clamp_val  = 7'd90;
		for (int a = 0; a < 3; a++) begin
			est_q[a] = '0;
			cov_q[a] = COV_W'(1 << FRAC);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: field extremes, clamp edges, estimate overflow
		pending_samples.push_back('{0, 0, 0});
		pending_samples.push_back('{32767, -32768, 1});
		pending_samples.push_back('{-32768, 32767, -1});
		pending_samples.push_back('{89, -89, 90});
		pending_samples.push_back('{-90, 90, 0});
		pending_samples.push_back('{32767, 32767, -32768});
		pending_samples.push_back('{16'sh5555, 16'shaaaa, 0});
		pending_samples.push_back('{0, 0, 0});
		wait_drained();

		// covariance saturation, zero measurement noise, zero threshold
		set_filter(16'hffff, 16'd0, 16'd0, 16'd127);
		pending_samples.push_back('{5, -5, 0});
		pending_samples.push_back('{16'shaaaa, 16'sh5555, -1});
		pending_samples.push_back('{-1, 1, 0});
		wait_drained();

		// both noises zero: covariance stuck at zero gives zero gain
		set_filter(16'd0, 16'd0, 16'd127, 16'd0);
		pending_samples.push_back('{100, -100, 32767});
		pending_samples.push_back('{-32768, 127, -127});
		pending_samples.push_back('{0, 0, 0});
		wait_drained();

		// random phases: receiver-heavy idling, sender-heavy idling, none
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 23;
					sink_idle_pct = 76;
				end
				1: begin
					src_idle_pct  = 76;
					sink_idle_pct = 23;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int ch = 0; ch < 2; ch++) begin
				int c;
				random_filter();
				c = $urandom_range(300);
				drift_center = c - 150;
				repeat (150) pending_samples.push_back(random_word());
				// long receiver hold-off while the sender keeps offering
				if (ph == 2 && ch == 1)
					hold_req = hold_req + 1;
				wait_drained();
			end
		end

		if (err_count == 0 && expected_filt.size() == 0)
			$display("three_axis_scalar_kalman_tb passed");
		else
			$display("three_axis_scalar_kalman_tb failed");
		$finish;
	end

endmodule
